// ----- src/mlta_pkg.sv -----
// Package for the MAC learning table with aging.
// Holds the command codes, table constants and the search status type.
// Has no dependencies; used by mlta_search and the top level.
package mlta_pkg;

    localparam int MAC_W         = 48;
    localparam int PORT_W        = 8;
    localparam int VLAN_W        = 16;
    localparam int AGE_W         = 8;
    localparam int ETYPE_W       = 16;
    localparam int ENTRY_INDEX_W = 6;
    localparam int ENTRY_W       = MAC_W + PORT_W + VLAN_W;

    localparam logic [AGE_W-1:0]   AGE_FRESH    = 8'hFF;
    localparam logic [AGE_W-1:0]   AGE_LAST     = 8'h01;
    localparam logic [AGE_W-1:0]   AGE_FREE     = 8'h00;
    localparam logic [PORT_W-1:0]  PORT_NONE    = 8'hFF;
    localparam logic [VLAN_W-1:0]  VLAN_NONE    = 16'h0000;
    localparam logic [ETYPE_W-1:0] TAG_TYPE     = 16'h8100;
    localparam logic [MAC_W-1:0]   MAC_ALL_ONES = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        KIND_LEARN  = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_TICK   = 2'd2,
        KIND_FLUSH  = 2'd3
    } t_kind;

    typedef struct packed {
        logic match;
        logic free;
    } t_search_flags;

endpackage

// ----- src/mlta_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// Width and depth are parameters. No dependencies.
module mlta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/mlta_search.sv -----
// Search unit of the MAC learning table: watches the entries streamed out of the
// tables and keeps the first live match, the first free entry and the oldest entry.
// Depends on mlta_pkg.
module mlta_search
    import mlta_pkg::*;
#(
    parameter int AW = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_valid,
    input  logic [AW-1:0]       i_idx,
    input  logic [AGE_W-1:0]    i_age,
    input  logic [ENTRY_W-1:0]  i_entry,
    input  logic [MAC_W-1:0]    i_query,
    output t_search_flags       o_flags,
    output logic [AW-1:0]       o_match_idx,
    output logic [PORT_W-1:0]   o_match_port,
    output logic [VLAN_W-1:0]   o_match_vlan,
    output logic [AW-1:0]       o_free_idx,
    output logic [AW-1:0]       o_min_idx
);

    t_search_flags       r_flags;
    logic [AW-1:0]       r_match_idx;
    logic [PORT_W-1:0]   r_match_port;
    logic [VLAN_W-1:0]   r_match_vlan;
    logic [AW-1:0]       r_free_idx;
    logic [AW-1:0]       r_min_idx;
    logic [AGE_W-1:0]    r_min_age;

    logic [MAC_W-1:0]    w_mac;
    logic [PORT_W-1:0]   w_port;
    logic [VLAN_W-1:0]   w_vlan;
    logic                w_live;

    assign {w_mac, w_port, w_vlan} = i_entry;
    assign w_live = (i_age != AGE_FREE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_start) begin
            r_flags <= '0;
        end else if (i_valid) begin
            if (w_live && (w_mac == i_query)) begin
                r_flags.match <= 1'b1;
            end
            if (!w_live) begin
                r_flags.free <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_min_age <= AGE_FRESH;
            r_min_idx <= '0;
        end else if (i_valid) begin
            if (w_live && (w_mac == i_query) && !r_flags.match) begin
                r_match_idx  <= i_idx;
                r_match_port <= w_port;
                r_match_vlan <= w_vlan;
            end
            if (!w_live && !r_flags.free) begin
                r_free_idx <= i_idx;
            end
            if (i_age < r_min_age) begin
                r_min_age <= i_age;
                r_min_idx <= i_idx;
            end
        end
    end

    assign o_flags      = r_flags;
    assign o_match_idx  = r_match_idx;
    assign o_match_port = r_match_port;
    assign o_match_vlan = r_match_vlan;
    assign o_free_idx   = r_free_idx;
    assign o_min_idx    = r_min_idx;

endmodule

// ----- src/mac_learning_table_aging_top.sv -----
// Top level of the MAC learning table with aging.
// Depends on mlta_pkg, mlta_ram and mlta_search.
//
// Usage:
// Commands enter on the input channel (i_valid, o_stall) and each one gives
// exactly one result transaction on the output channel (o_valid, i_stall).
// A transaction is accepted at a rising edge where valid is high and stall low.
// Learn, lookup, aging tick and flush all sweep the whole table once through
// the age and entry memories, one entry per cycle, before the result is
// presented; an ignored learn of the all-ones MAC skips the sweep.
// The sweep length is set by the single read port of the tables.
// One command is worked on at a time; the next is accepted as soon as the
// result has moved to the output register, even while it is still stalled.
// After reset the age memory is cleared one entry per cycle, and o_stall
// stays high until that has finished.
// While the receiver stalls, the result holds; a second finished result waits
// inside the block until the output register is free.
module mac_learning_table_aging_top
    import mlta_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_kind,
    input  logic [MAC_W-1:0]         i_mac,
    input  logic [ETYPE_W-1:0]       i_ether_type,
    input  logic [VLAN_W-1:0]        i_tag_control,
    input  logic [PORT_W-1:0]        i_port,
    input  logic [VLAN_W-1:0]        i_vid,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_hit,
    output logic [PORT_W-1:0]        o_found_port,
    output logic [VLAN_W-1:0]        o_found_vlan,
    output logic [ENTRY_INDEX_W-1:0] o_entry_index
);

    localparam int AW    = $clog2(TABLE_ENTRIES);
    localparam int EXT_W = AW + ENTRY_INDEX_W;
    localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

    typedef enum logic [4:0] {
        S_CLEAR   = 5'b00001,
        S_IDLE    = 5'b00010,
        S_SCAN    = 5'b00100,
        S_RESOLVE = 5'b01000,
        S_DONE    = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [AW-1:0]             r_addr;
    logic                      r_issue;
    logic                      r_rd_vld;
    logic [AW-1:0]             r_rd_idx;

    t_kind                     r_kind;
    logic [MAC_W-1:0]          r_mac;
    logic [PORT_W-1:0]         r_port;
    logic [VLAN_W-1:0]         r_vlan;

    logic                      r_res_hit;
    logic [PORT_W-1:0]         r_res_port;
    logic [VLAN_W-1:0]         r_res_vlan;
    logic [ENTRY_INDEX_W-1:0]  r_res_idx;

    logic                      r_out_valid;
    logic                      r_out_hit;
    logic [PORT_W-1:0]         r_out_port;
    logic [VLAN_W-1:0]         r_out_vlan;
    logic [ENTRY_INDEX_W-1:0]  r_out_idx;

    logic                      w_accept;
    logic                      w_ignore;
    logic                      w_out_load;
    logic                      w_scan_end;

    logic                      w_age_we;
    logic [AW-1:0]             w_age_waddr;
    logic [AGE_W-1:0]          w_age_wdata;
    logic [AGE_W-1:0]          w_age_rdata;
    logic                      w_entry_we;
    logic [ENTRY_W-1:0]        w_entry_rdata;

    t_search_flags             w_flags;
    logic [AW-1:0]             w_match_idx;
    logic [PORT_W-1:0]         w_match_port;
    logic [VLAN_W-1:0]         w_match_vlan;
    logic [AW-1:0]             w_free_idx;
    logic [AW-1:0]             w_min_idx;
    logic [AW-1:0]             w_target;
    logic [EXT_W-1:0]          w_target_ext;
    logic [EXT_W-1:0]          w_match_ext;

    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_ignore   = (t_kind'(i_kind) == KIND_LEARN) && (i_mac == MAC_ALL_ONES);
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || !i_stall);
    assign w_scan_end = r_rd_vld && (r_rd_idx == LAST);

    assign w_target = w_flags.match ? w_match_idx :
                      (w_flags.free ? w_free_idx : w_min_idx);
    assign w_target_ext = EXT_W'(w_target);
    assign w_match_ext  = EXT_W'(w_match_idx);

    mlta_ram #(
        .WIDTH (AGE_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_age_ram (
        .i_clk   (i_clk),
        .i_we    (w_age_we),
        .i_waddr (w_age_waddr),
        .i_wdata (w_age_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_age_rdata)
    );

    mlta_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_entry_we),
        .i_waddr (w_target),
        .i_wdata ({r_mac, r_port, r_vlan}),
        .i_raddr (r_addr),
        .o_rdata (w_entry_rdata)
    );

    mlta_search #(
        .AW (AW)
    ) u_search (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_accept),
        .i_valid      (r_rd_vld),
        .i_idx        (r_rd_idx),
        .i_age        (w_age_rdata),
        .i_entry      (w_entry_rdata),
        .i_query      (r_mac),
        .o_flags      (w_flags),
        .o_match_idx  (w_match_idx),
        .o_match_port (w_match_port),
        .o_match_vlan (w_match_vlan),
        .o_free_idx   (w_free_idx),
        .o_min_idx    (w_min_idx)
    );

    always_comb begin
        w_age_we    = 1'b0;
        w_age_waddr = r_addr;
        w_age_wdata = AGE_FREE;
        if (r_state == S_CLEAR) begin
            w_age_we = 1'b1;
        end else if ((r_state == S_SCAN) && r_rd_vld &&
                     ((r_kind == KIND_TICK) || (r_kind == KIND_FLUSH))) begin
            w_age_we    = 1'b1;
            w_age_waddr = r_rd_idx;
            if (w_age_rdata == AGE_FREE) begin
                w_age_wdata = AGE_FREE;
            end else if (r_kind == KIND_TICK) begin
                w_age_wdata = w_age_rdata - AGE_LAST;
            end else begin
                w_age_wdata = AGE_LAST;
            end
        end else if ((r_state == S_RESOLVE) && (r_kind == KIND_LEARN)) begin
            w_age_we    = 1'b1;
            w_age_waddr = w_target;
            w_age_wdata = AGE_FRESH;
        end
    end

    assign w_entry_we = (r_state == S_RESOLVE) && (r_kind == KIND_LEARN);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_addr == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_state = w_ignore ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_scan_end) begin
                    n_state = S_RESOLVE;
                end
            end
            S_RESOLVE: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_addr   <= '0;
            r_issue  <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_SCAN) && r_issue;
            if (r_state == S_CLEAR) begin
                r_addr <= (r_addr == LAST) ? '0 : r_addr + 1'b1;
            end else if (w_accept) begin
                r_addr  <= '0;
                r_issue <= 1'b1;
            end else if ((r_state == S_SCAN) && r_issue) begin
                if (r_addr == LAST) begin
                    r_issue <= 1'b0;
                end else begin
                    r_addr <= r_addr + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
        if (w_accept) begin
            r_kind <= t_kind'(i_kind);
            r_mac  <= i_mac;
            r_port <= i_port;
            r_vlan <= (i_ether_type == TAG_TYPE) ? i_tag_control : i_vid;
            r_res_hit  <= 1'b0;
            r_res_port <= PORT_NONE;
            r_res_vlan <= VLAN_NONE;
            r_res_idx  <= '0;
        end else if (r_state == S_RESOLVE) begin
            case (r_kind)
                KIND_LEARN: begin
                    r_res_hit  <= 1'b1;
                    r_res_port <= r_port;
                    r_res_vlan <= r_vlan;
                    r_res_idx  <= w_target_ext[ENTRY_INDEX_W-1:0];
                end
                KIND_LOOKUP: begin
                    if (w_flags.match) begin
                        r_res_hit  <= 1'b1;
                        r_res_port <= w_match_port;
                        r_res_vlan <= w_match_vlan;
                        r_res_idx  <= w_match_ext[ENTRY_INDEX_W-1:0];
                    end
                end
                default: begin
                    r_res_hit <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_hit  <= r_res_hit;
            r_out_port <= r_res_port;
            r_out_vlan <= r_res_vlan;
            r_out_idx  <= r_res_idx;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_hit         = r_out_hit;
    assign o_found_port  = r_out_port;
    assign o_found_vlan  = r_out_vlan;
    assign o_entry_index = r_out_idx;

endmodule
